FILE: rtl/sso_pkg.sv
// Package for the sine/square oscillator: sizes, codes and the quarter-wave sine table.
`default_nettype none
package sso_pkg;

  // Sizes
  localparam int PHASE_BITS      = 32;
  localparam int TABLE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS     = 16;
  localparam int ANGLE_BITS      = 16;
  localparam int QUAD_ADDR_BITS  = ANGLE_BITS - 2;
  localparam int TABLE_N         = 1 << TABLE_ADDR_BITS;
  localparam int TABLE_IDX_BITS  = TABLE_ADDR_BITS + 1;
  localparam int MAG_BITS        = SAMPLE_BITS - 1;
  localparam int FULL_SCALE      = (1 << (SAMPLE_BITS - 1)) - 1;

  // Register port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int STEP_BITS      = 32;
  localparam int OFFSET_BITS    = 16;
  localparam int MODE_BITS      = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_OFFSET = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_MODE    = 2'd2;

  localparam logic [STEP_BITS-1:0] STEP_RESET = 32'd39370534;

  // Waveform codes; the unused code plays sine
  localparam logic [MODE_BITS-1:0] MODE_SINE   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_HALF   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_SQUARE = 2'd2;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [MAG_BITS-1:0] sine_rom_t [TABLE_N+1];

  // Two Q30 multiplies by x
  function automatic logic [63:0] q30_mul2(input logic [63:0] term, input logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  // Taylor series of sin through x^13, scaled to full scale and rounded
  function automatic logic [MAG_BITS-1:0] quarter_sine(input int unsigned i);
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    longint      v;
    x    = (HALF_PI_Q30 * 64'(i)) >> TABLE_ADDR_BITS;
    term = x;
    sum  = longint'(x);
    term = q30_mul2(term, x) / 64'd6;
    sum  = sum - longint'(term);
    term = q30_mul2(term, x) / 64'd20;
    sum  = sum + longint'(term);
    term = q30_mul2(term, x) / 64'd42;
    sum  = sum - longint'(term);
    term = q30_mul2(term, x) / 64'd72;
    sum  = sum + longint'(term);
    term = q30_mul2(term, x) / 64'd110;
    sum  = sum - longint'(term);
    term = q30_mul2(term, x) / 64'd156;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = longint'((64'(sum) * 64'(FULL_SCALE) + 64'd536870912) >> 30);
    if (v > longint'(FULL_SCALE)) begin
      v = longint'(FULL_SCALE);
    end
    return MAG_BITS'(v);
  endfunction

  function automatic sine_rom_t build_table();
    sine_rom_t t;
    for (int i = 0; i <= TABLE_N; i++) begin
      t[i] = quarter_sine(i);
    end
    return t;
  endfunction

  // Quarter wave, entries 0 to TABLE_N inclusive
  localparam sine_rom_t SINE_TABLE = build_table();

endpackage
`default_nettype wire

FILE: rtl/sine_square_oscillator.sv
// Top level of the sine/square oscillator: phase accumulator, sine ROM and waveform stage.
//
// One input item (a tick, with a restart flag) gives one output sample.
// The in_ channel takes ticks with valid/ready; the out_ channel gives
// samples in Q1.15 (32767 = 1.0) with valid/ready. The cfg_ channel writes
// the tuning word (index 0), the phase offset (index 1) and the waveform
// (index 2: sine, half square, square); it is always ready and should be
// written only while no tick is in flight.
// Each accepted tick passes through the stage 1 index register (loaded at
// the accepting edge), the registered sine ROM read and the output register.
// Throughput: one tick per cycle unless the receiver stalls, set by the
// single accumulator add that runs per accepted tick.
// The phase accumulator advances when a tick is accepted; restart clears it
// first, and a zero tuning word clears it after the sample.
// Reset clears the accumulator, empties the pipeline and loads the register
// defaults. When the receiver stalls, each stage holds its item and bubbles
// ahead of it still fill, so up to three ticks are taken before in_ready
// drops.
`default_nettype none
module sine_square_oscillator (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic                                 in_restart,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [sso_pkg::SAMPLE_BITS-1:0]    out_sample,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [sso_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [sso_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  // Configuration registers
  logic [sso_pkg::STEP_BITS-1:0]   phase_step_r;
  logic [sso_pkg::OFFSET_BITS-1:0] phase_offset_r;
  logic [sso_pkg::MODE_BITS-1:0]   wave_mode_r;

  // Accumulator and pipeline
  logic [sso_pkg::PHASE_BITS-1:0]     acc_r;
  logic [sso_pkg::PHASE_BITS-1:0]     acc_cur;
  logic [sso_pkg::PHASE_BITS-1:0]     acc_nxt;
  logic [sso_pkg::ANGLE_BITS-1:0]     angle;
  logic [sso_pkg::TABLE_ADDR_BITS-1:0] addr;
  logic [sso_pkg::TABLE_IDX_BITS-1:0] idx_nxt;
  logic [sso_pkg::TABLE_IDX_BITS-1:0] idx1_r;
  logic                               neg1_r;
  logic                               v1_r;
  logic [sso_pkg::MAG_BITS-1:0]       rom_r;
  logic                               neg2_r;
  logic                               v2_r;
  logic signed [sso_pkg::SAMPLE_BITS-1:0] mag_s;
  logic signed [sso_pkg::SAMPLE_BITS-1:0] sine_s;
  logic signed [sso_pkg::SAMPLE_BITS-1:0] sample_nxt;
  logic signed [sso_pkg::SAMPLE_BITS-1:0] sample_r;
  logic                               out_valid_r;
  logic                               sign_pos;
  logic                               ready_o;
  logic                               ready2;
  logic                               ready1;
  logic                               in_accept;

  // Stage handshakes: a stage takes a new item when empty or when it drains
  assign ready_o   = !out_valid_r || out_ready;
  assign ready2    = !v2_r || ready_o;
  assign ready1    = !v1_r || ready2;
  assign in_ready  = ready1;
  assign in_accept = in_valid && ready1;
  assign cfg_ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= sso_pkg::STEP_RESET;
      phase_offset_r <= '0;
      wave_mode_r    <= sso_pkg::MODE_SINE;
    end else if (cfg_valid) begin
      case (cfg_index)
        sso_pkg::REG_PHASE_STEP:   phase_step_r   <= sso_pkg::STEP_BITS'(cfg_data);
        sso_pkg::REG_PHASE_OFFSET: phase_offset_r <= sso_pkg::OFFSET_BITS'(cfg_data);
        sso_pkg::REG_WAVE_MODE:    wave_mode_r    <= sso_pkg::MODE_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // Angle from the accumulator, folded into a quarter-wave index
  always_comb begin
    acc_cur = in_restart ? '0 : acc_r;
    angle   = acc_cur[sso_pkg::PHASE_BITS-1 -: sso_pkg::ANGLE_BITS] - phase_offset_r;
    addr    = angle[sso_pkg::QUAD_ADDR_BITS-1 -: sso_pkg::TABLE_ADDR_BITS];
    if (angle[sso_pkg::ANGLE_BITS-2]) begin
      idx_nxt = sso_pkg::TABLE_IDX_BITS'(sso_pkg::TABLE_N) - {1'b0, addr};
    end else begin
      idx_nxt = {1'b0, addr};
    end
    if (phase_step_r == '0) begin
      acc_nxt = '0;
    end else begin
      acc_nxt = acc_cur + sso_pkg::PHASE_BITS'(phase_step_r);
    end
  end

  // Accumulator and stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      v1_r  <= 1'b0;
    end else begin
      if (in_accept) begin
        acc_r <= acc_nxt;
      end
      if (ready1) begin
        v1_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      idx1_r <= idx_nxt;
      neg1_r <= angle[sso_pkg::ANGLE_BITS-1];
    end
  end

  // Stage 2: registered sine ROM read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ready2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      rom_r  <= sso_pkg::SINE_TABLE[idx1_r];
      neg2_r <= neg1_r;
    end
  end

  // Sign and waveform selection
  always_comb begin
    mag_s    = signed'({1'b0, rom_r});
    sine_s   = neg2_r ? -mag_s : mag_s;
    sign_pos = !neg2_r || (rom_r == '0);
    case (wave_mode_r)
      sso_pkg::MODE_HALF: begin
        sample_nxt = sign_pos ? sso_pkg::SAMPLE_BITS'(sso_pkg::FULL_SCALE) : '0;
      end
      sso_pkg::MODE_SQUARE: begin
        sample_nxt = sign_pos ? sso_pkg::SAMPLE_BITS'(sso_pkg::FULL_SCALE)
                              : -sso_pkg::SAMPLE_BITS'(sso_pkg::FULL_SCALE);
      end
      default: begin
        sample_nxt = sine_s;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ready_o) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && v2_r) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;

  // Checks
  a_no_min_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_sample != {1'b1, {(sso_pkg::SAMPLE_BITS-1){1'b0}}})
    else $error("sample took the most negative code");

  a_zero_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && phase_step_r == '0) |=> acc_r == '0)
    else $error("accumulator not cleared with zero tuning word");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !ready2) |=> (v1_r && $stable(idx1_r) && $stable(neg1_r)))
    else $error("stage 1 item lost during stall");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !ready_o) |=> (v2_r && $stable(rom_r) && $stable(neg2_r)))
    else $error("stage 2 item lost during stall");

endmodule
`default_nettype wire

FILE: dv/tb_sine_square_oscillator.sv
// Self-checking testbench for the sine/square oscillator: phase model, sample compare, stalls.
`timescale 1ns / 100ps
module tb_sine_square_oscillator;
  import sso_pkg::*;

  localparam int                 WATCHDOG_LIMIT = 2000;
  localparam longint unsigned    PI_HALF_Q30    = 64'd1686629713;

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_valid   = 1'b0;
  logic                          in_ready;
  logic                          in_restart = 1'b0;
  logic                          out_valid;
  logic                          out_ready  = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [CFG_INDEX_BITS-1:0]     cfg_index  = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data   = '0;

  // Oscillator model state and its copy of the registers
  logic [PHASE_BITS-1:0]         phase_acc  = '0;
  logic [STEP_BITS-1:0]          cur_step   = STEP_RESET;
  logic [OFFSET_BITS-1:0]        cur_offset = '0;
  logic [MODE_BITS-1:0]          cur_mode   = MODE_SINE;
  logic [MAG_BITS-1:0]           quarter_wave [0:TABLE_N];

  logic signed [SAMPLE_BITS-1:0] expected_samples [$];
  int                            err_count   = 0;
  int                            idle_cycles = 0;
  int                            out_hold    = 0;
  bit                            in_idle_on  = 1'b0;
  bit                            out_idle_on = 1'b0;

  sine_square_oscillator u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One quarter-wave entry: Q30 Taylor series of sin through x^13, rounded to full scale
  function automatic int sine_entry(input int unsigned idx);
    longint unsigned arg;
    longint unsigned pw;
    longint          acc;
    longint          rounded;
    int              k;
    arg = idx;
    arg = (PI_HALF_Q30 * arg) >> TABLE_ADDR_BITS;
    pw  = arg;
    acc = arg;
    for (k = 1; k <= 6; k++) begin
      pw = (pw * arg) >> 30;
      pw = (pw * arg) >> 30;
      pw = pw / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(pw);
      else            acc = acc + longint'(pw);
    end
    if (acc < 0) acc = 0;
    rounded = (acc * FULL_SCALE + 64'd536870912) >>> 30;
    if (rounded > FULL_SCALE) rounded = FULL_SCALE;
    return int'(rounded);
  endfunction

  initial begin
    for (int i = 0; i <= TABLE_N; i++) begin
      quarter_wave[i] = sine_entry(i);
    end
  end

  // Expected sample for one tick; advances the modeled accumulator
  function automatic logic signed [SAMPLE_BITS-1:0] next_sample(input logic restart);
    logic [ANGLE_BITS-1:0]      ang;
    logic [TABLE_ADDR_BITS-1:0] addr;
    int                         mag;
    int                         val;
    if (restart) phase_acc = '0;
    ang  = phase_acc[PHASE_BITS-1 -: ANGLE_BITS] - cur_offset;
    addr = ang[QUAD_ADDR_BITS-1 -: TABLE_ADDR_BITS];
    mag  = ang[ANGLE_BITS-2] ? quarter_wave[TABLE_N - addr] : quarter_wave[addr];
    val  = ang[ANGLE_BITS-1] ? -mag : mag;
    case (cur_mode)
      MODE_HALF:   val = (val >= 0) ? FULL_SCALE : 0;
      MODE_SQUARE: val = (val >= 0) ? FULL_SCALE : -FULL_SCALE;
      default: ;
    endcase
    if (cur_step == '0) phase_acc = '0;
    else                phase_acc = phase_acc + cur_step;
    return val[SAMPLE_BITS-1:0];
  endfunction

  // Monitor: register writes, sample check, tick prediction, watchdog
  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] exp_sample;
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PHASE_STEP:   cur_step   = cfg_data[STEP_BITS-1:0];
          REG_PHASE_OFFSET: cur_offset = cfg_data[OFFSET_BITS-1:0];
          REG_WAVE_MODE:    cur_mode   = cfg_data[MODE_BITS-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_hold = out_idle_on ? $urandom_range(0, 10) : 0;
        if (expected_samples.size() == 0) begin
          $error("sample arrived with no tick outstanding: actual %0d", out_sample);
          err_count++;
        end else begin
          exp_sample = expected_samples.pop_front();
          if (out_sample !== exp_sample) begin
            $error("sample mismatch: expected %0d, actual %0d", exp_sample, out_sample);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_samples.push_back(next_sample(in_restart));
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: hold off for the drawn number of cycles after each sample
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold = out_hold - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Send one tick; entered and left just after a falling edge
  task automatic send_tick(input logic restart);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 10) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait until every outstanding sample has been checked
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_samples.size() != 0) @(negedge clk);
  endtask

  // Register write, only with the pipeline empty
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Register defaults after reset
  task automatic test_reset_defaults();
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Restart in the middle of a run clears the phase before the sample
  task automatic test_restart();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // Zero tuning word holds the phase at zero
  task automatic test_zero_step();
    write_reg(REG_PHASE_STEP, '0);
    write_reg(REG_PHASE_OFFSET, 32'h0000_1234);
    repeat (3) send_tick(1'b0);
  endtask

  // Nyquist tuning word with the largest offset
  task automatic test_nyquist_step();
    write_reg(REG_PHASE_STEP, 32'h8000_0000);
    write_reg(REG_PHASE_OFFSET, 32'h0000_FFFF);
    repeat (3) send_tick(1'b0);
  endtask

  // Every waveform code at quadrant boundaries; the half-turn point gives a zero sine
  task automatic test_wave_modes();
    logic [MODE_BITS-1:0] m;
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    write_reg(REG_PHASE_OFFSET, '0);
    for (int i = 0; i < 4; i++) begin
      m = i;
      write_reg(REG_WAVE_MODE, CFG_DATA_BITS'(m));
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
    end
  endtask

  // Random phases: new settings, idle pattern and one full pause each
  task automatic test_random_phases();
    logic [STEP_BITS-1:0]   step;
    logic [OFFSET_BITS-1:0] offs;
    int                     pause_at;
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       step = '0;
        1:       step = 32'h8000_0000;
        2:       step = 32'd1;
        default: step = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h8000_0000)
                                                     : $urandom_range(1, 32'h07FF_FFFF);
      endcase
      case (ph)
        1:       offs = 16'hFFFF;
        2:       offs = '0;
        default: offs = $urandom_range(0, 16'hFFFF);
      endcase
      write_reg(REG_PHASE_STEP, step);
      write_reg(REG_PHASE_OFFSET, CFG_DATA_BITS'(offs));
      write_reg(REG_WAVE_MODE, CFG_DATA_BITS'(ph % 4));
      in_idle_on  = ($urandom_range(0, 2) != 0);
      out_idle_on = ($urandom_range(0, 2) != 0);
      pause_at    = $urandom_range(0, 99);
      for (int k = 0; k < 100; k++) begin
        if (k == pause_at) drain_results();
        send_tick($urandom_range(0, 15) == 0);
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_restart();
    test_zero_step();
    test_nyquist_step();
    test_wave_modes();
    test_random_phases();
    drain_results();
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
